@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker modules of the core.
// Needs nothing else; the clock and reset are passed in at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("concurrent assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("concurrent assertion failed");

`endif

@@ rtl/core/spq_pkg.sv @@
// Shared types and constants of the sorted priority queue core.
// Depends on nothing; every other file of the core but assert_macros.svh imports it.
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int ID_W = 16;
   localparam int PRIO_W = 4;
   localparam int RSP_CNT_W = 5;
   localparam int STATUS_W = 2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(DEPTH);
   localparam logic [RSP_CNT_W-1:0] RSP_COUNT_FULL = RSP_CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_REJECT_FULL,
      OP_REJECT_EMPTY
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dp_status_type;

endpackage

@@ rtl/core/spq_channels.sv @@
// Valid/ready channel interfaces for requests and responses of the queue.
// Depends on spq_pkg for the payload widths.
interface spq_req_if import spq_pkg::*; ();
   logic valid;
   logic ready;
   logic cmd;
   logic [ID_W-1:0] item_id;
   logic [PRIO_W-1:0] priority_req;

   modport source (output valid, output cmd, output item_id, output priority_req,
                   input ready);
   modport sink (input valid, input cmd, input item_id, input priority_req,
                 output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic valid;
   logic ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0] out_id;
   logic [PRIO_W-1:0] out_priority;
   logic [RSP_CNT_W-1:0] count;

   modport source (output valid, output status, output out_id, output out_priority,
                   output count, input ready);
   modport sink (input valid, input status, input out_id, input out_priority,
                 input count, output ready);
endinterface

@@ rtl/core/spq_datapath.sv @@
// Datapath of the queue: a row of compare-and-shift cells, the entry count
// and the response register. Depends on spq_pkg; driven by spq_controller.
module spq_datapath import spq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           dp_cmd,
   input  logic [ID_W-1:0]      item_id,
   input  logic [PRIO_W-1:0]    priority_req,
   output dp_status_type        dp_status,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [ID_W-1:0]      rsp_id,
   output logic [PRIO_W-1:0]    rsp_priority,
   output logic [RSP_CNT_W-1:0] rsp_count
);

   logic [ID_W-1:0]      id_ff [DEPTH];
   logic [ID_W-1:0]      id_in [DEPTH];
   logic [PRIO_W-1:0]    prio_ff [DEPTH];
   logic [PRIO_W-1:0]    prio_in [DEPTH];
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [DEPTH-1:0]     later;
   logic [STATUS_W-1:0]  status_ff;
   logic [STATUS_W-1:0]  status_in;
   logic [ID_W-1:0]      out_id_ff;
   logic [ID_W-1:0]      out_id_in;
   logic [PRIO_W-1:0]    out_prio_ff;
   logic [PRIO_W-1:0]    out_prio_in;
   logic [RSP_CNT_W-1:0] out_count_ff;
   logic [RSP_CNT_W-1:0] out_count_in;

   assign dp_status.full = (count_ff == COUNT_FULL);
   assign dp_status.empty = (count_ff == '0);

   // A held entry sorts after the new one when its priority is strictly less urgent.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         later[i] = (CNT_W'(i) < count_ff) && (prio_ff[i] > priority_req);
      end
   end

   always_comb begin
      logic prev_later;
      prev_later = 1'b0;
      count_in = count_ff;
      status_in = status_ff;
      out_id_in = out_id_ff;
      out_prio_in = out_prio_ff;
      for (int i = 0; i < DEPTH; i++) begin
         id_in[i] = id_ff[i];
         prio_in[i] = prio_ff[i];
      end
      unique case (dp_cmd.op)
         OP_INSERT: begin
            for (int i = 0; i < DEPTH; i++) begin
               prev_later = (i == 0) ? 1'b0 : later[(i == 0) ? 0 : i - 1];
               if (prev_later) begin
                  id_in[i] = id_ff[(i == 0) ? 0 : i - 1];
                  prio_in[i] = prio_ff[(i == 0) ? 0 : i - 1];
               end else if (later[i] || (CNT_W'(i) == count_ff)) begin
                  id_in[i] = item_id;
                  prio_in[i] = priority_req;
               end
            end
            count_in = count_ff + CNT_W'(1);
            status_in = ST_OK;
            out_id_in = '0;
            out_prio_in = '0;
         end
         OP_REMOVE: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               id_in[i] = id_ff[i + 1];
               prio_in[i] = prio_ff[i + 1];
            end
            count_in = count_ff - CNT_W'(1);
            status_in = ST_OK;
            out_id_in = id_ff[0];
            out_prio_in = prio_ff[0];
         end
         OP_REJECT_FULL: begin
            status_in = ST_FULL;
            out_id_in = '0;
            out_prio_in = '0;
         end
         OP_REJECT_EMPTY: begin
            status_in = ST_EMPTY;
            out_id_in = '0;
            out_prio_in = '0;
         end
         default: begin
         end
      endcase
      out_count_in = (dp_cmd.op == OP_NONE) ? out_count_ff : RSP_CNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         id_ff[i] <= id_in[i];
         prio_ff[i] <= prio_in[i];
      end
      status_ff <= status_in;
      out_id_ff <= out_id_in;
      out_prio_ff <= out_prio_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_status = status_ff;
   assign rsp_id = out_id_ff;
   assign rsp_priority = out_prio_ff;
   assign rsp_count = out_count_ff;

endmodule

@@ rtl/core/spq_controller.sv @@
// Controller of the queue: accepts requests, picks the datapath operation
// and owns the response valid. Depends on spq_pkg.
module spq_controller import spq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic {
      IDLE,
      RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // A new request may be taken in the cycle the pending response is transferred.
   assign req_ready = (state_ff == IDLE) || rsp_ready;
   assign accept = req_valid && req_ready;
   assign rsp_valid = (state_ff == RESP);

   always_comb begin
      dp_cmd.op = OP_NONE;
      if (accept) begin
         if (req_cmd == CMD_INSERT) begin
            dp_cmd.op = dp_status.full ? OP_REJECT_FULL : OP_INSERT;
         end else begin
            dp_cmd.op = dp_status.empty ? OP_REJECT_EMPTY : OP_REMOVE;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               state_in = RESP;
            end
         end
         RESP: begin
            if (rsp_ready && !accept) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/sorted_priority_queue_core.sv @@
// Channel   Dir  Payload                                    Transfer
// req_ch    in   cmd, item_id, priority_req                 valid & ready
// rsp_ch    out  status, out_id, out_priority, count        valid & ready
//
// Each request is executed in the cycle it is accepted; the response appears
// registered in the next cycle, and one request per cycle is sustained while
// responses are taken at once.
// A waiting response stalls further requests until it is transferred.
// Synchronous active-high reset empties the queue and drops any pending response.
// Depends on spq_pkg, spq_channels, spq_controller and spq_datapath.
module sorted_priority_queue_core import spq_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   spq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   spq_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .dp_cmd       (dp_cmd),
      .item_id      (req_ch.item_id),
      .priority_req (req_ch.priority_req),
      .dp_status    (dp_status),
      .rsp_status   (rsp_ch.status),
      .rsp_id       (rsp_ch.out_id),
      .rsp_priority (rsp_ch.out_priority),
      .rsp_count    (rsp_ch.count)
   );

endmodule

@@ rtl/core/spq_checker.sv @@
// Port-level checker for sorted_priority_queue_core and its bind statement.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_checker import spq_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [ID_W-1:0]      rsp_out_id,
   input logic [PRIO_W-1:0]    rsp_out_priority,
   input logic [RSP_CNT_W-1:0] rsp_count
);

   logic reset_off;
   assign reset_off = 1'b0;

   `ASSERT_NEXT(a_no_rsp_after_reset, clock, reset_off, reset, !rsp_valid)
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_out_id) && $stable(rsp_count))
   `ASSERT_IMPLIES(a_reject_no_entry, clock, reset, rsp_valid && (rsp_status != ST_OK), (rsp_out_id == '0) && (rsp_out_priority == '0))
   `ASSERT_IMPLIES(a_full_count, clock, reset, rsp_valid && (rsp_status == ST_FULL), rsp_count == RSP_COUNT_FULL)
   `ASSERT_IMPLIES(a_empty_count, clock, reset, rsp_valid && (rsp_status == ST_EMPTY), rsp_count == '0)

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_out_id       (rsp_ch.out_id),
   .rsp_out_priority (rsp_ch.out_priority),
   .rsp_count        (rsp_ch.count)
);

@@ tb/sv/tb_sorted_priority_queue_core.sv @@
// Self-checking testbench for sorted_priority_queue_core: a directed table, then random
// fill, drain and mixed phases; responses are checked against a shadow sorted queue,
// or the table for fixed rows. Depends on spq_pkg, spq_req_if, spq_rsp_if and the core.
module tb_sorted_priority_queue_core;
   import spq_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_ROWS = 25;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0] out_id;
      logic [PRIO_W-1:0] out_priority;
      logic [RSP_CNT_W-1:0] count;
   } queue_rsp_t;

   typedef struct packed {
      logic cmd;
      logic [ID_W-1:0] item_id;
      logic [PRIO_W-1:0] prio;
      logic fixed;
      queue_rsp_t rsp;
   } plan_row_t;

   logic clock;
   logic reset;

   spq_req_if req_ch();
   spq_rsp_if rsp_ch();

   sorted_priority_queue_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [ID_W-1:0] shadow_ids [DEPTH];
   logic [PRIO_W-1:0] shadow_prios [DEPTH];
   int shadow_held;
   queue_rsp_t awaited_rsps [$];
   int mismatches;
   int rsp_hold;
   int quiet_cycles;
   bit no_idle;

   plan_row_t directed_plan [DIRECTED_ROWS] = '{
      '{CMD_REMOVE, 16'h0000, 4'h0, 1'b1, '{ST_EMPTY, 16'h0000, 4'h0, 5'd0}},
      '{CMD_INSERT, 16'hFFFF, 4'hF, 1'b1, '{ST_OK, 16'h0000, 4'h0, 5'd1}},
      '{CMD_INSERT, 16'h0000, 4'h0, 1'b1, '{ST_OK, 16'h0000, 4'h0, 5'd2}},
      '{CMD_REMOVE, 16'h1234, 4'h9, 1'b1, '{ST_OK, 16'h0000, 4'h0, 5'd1}},
      '{CMD_REMOVE, 16'h0000, 4'h0, 1'b1, '{ST_OK, 16'hFFFF, 4'hF, 5'd0}},
      '{CMD_REMOVE, 16'hFFFF, 4'hF, 1'b1, '{ST_EMPTY, 16'h0000, 4'h0, 5'd0}},
      '{CMD_INSERT, 16'hA5A5, 4'h7, 1'b0, '0},
      '{CMD_INSERT, 16'h5A5A, 4'h3, 1'b0, '0},
      '{CMD_INSERT, 16'h0001, 4'h7, 1'b0, '0},
      '{CMD_INSERT, 16'h8000, 4'hF, 1'b0, '0},
      '{CMD_INSERT, 16'h0002, 4'h0, 1'b0, '0},
      '{CMD_INSERT, 16'h0003, 4'h7, 1'b0, '0},
      '{CMD_INSERT, 16'h0004, 4'h3, 1'b0, '0},
      '{CMD_INSERT, 16'h0005, 4'hC, 1'b0, '0},
      '{CMD_INSERT, 16'h0006, 4'h7, 1'b0, '0},
      '{CMD_INSERT, 16'h0007, 4'h0, 1'b0, '0},
      '{CMD_INSERT, 16'h0008, 4'hF, 1'b0, '0},
      '{CMD_INSERT, 16'h0009, 4'h1, 1'b0, '0},
      '{CMD_INSERT, 16'h000A, 4'h7, 1'b0, '0},
      '{CMD_INSERT, 16'h000B, 4'h9, 1'b0, '0},
      '{CMD_INSERT, 16'h000C, 4'h3, 1'b0, '0},
      '{CMD_INSERT, 16'h000D, 4'hE, 1'b0, '0},
      '{CMD_INSERT, 16'hFFFF, 4'h0, 1'b1, '{ST_FULL, 16'h0000, 4'h0, RSP_COUNT_FULL}},
      '{CMD_REMOVE, 16'h0000, 4'h0, 1'b0, '0},
      '{CMD_REMOVE, 16'h0000, 4'h0, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one request to the shadow queue and returns the response it should cause.
   function automatic queue_rsp_t step_shadow_queue(input logic cmd,
                                                    input logic [ID_W-1:0] item_id,
                                                    input logic [PRIO_W-1:0] prio);
      queue_rsp_t rsp;
      int slot;
      rsp = '0;
      rsp.status = ST_OK;
      if (cmd == CMD_INSERT) begin
         if (shadow_held >= DEPTH) begin
            rsp.status = ST_FULL;
         end else begin
            slot = shadow_held;
            for (int i = 0; i < shadow_held; i++) begin
               if (shadow_prios[i] > prio) begin
                  slot = i;
                  break;
               end
            end
            for (int i = shadow_held; i > slot; i--) begin
               shadow_ids[i] = shadow_ids[i-1];
               shadow_prios[i] = shadow_prios[i-1];
            end
            shadow_ids[slot] = item_id;
            shadow_prios[slot] = prio;
            shadow_held++;
         end
      end else if (shadow_held == 0) begin
         rsp.status = ST_EMPTY;
      end else begin
         rsp.out_id = shadow_ids[0];
         rsp.out_priority = shadow_prios[0];
         for (int i = 1; i < shadow_held; i++) begin
            shadow_ids[i-1] = shadow_ids[i];
            shadow_prios[i-1] = shadow_prios[i];
         end
         shadow_held--;
      end
      rsp.count = RSP_CNT_W'(shadow_held);
      return rsp;
   endfunction

   // Mostly no pause, often a short one, now and then a long one.
   function automatic int random_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   task automatic send_request(input logic cmd, input logic [ID_W-1:0] item_id,
                               input logic [PRIO_W-1:0] prio, input logic fixed,
                               input queue_rsp_t fixed_rsp);
      int gap;
      queue_rsp_t predicted;
      gap = random_pause();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.item_id <= item_id;
      req_ch.priority_req <= prio;
      do @(posedge clock); while (!req_ch.ready);
      predicted = step_shadow_queue(cmd, item_id, prio);
      awaited_rsps.push_back(fixed ? fixed_rsp : predicted);
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
   endtask

   initial begin
      int phase_len;
      int insert_pct;
      int prio_lo;
      int prio_hi;
      int phase;
      int sent;
      logic cmd;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_INSERT;
      req_ch.item_id <= '0;
      req_ch.priority_req <= '0;
      shadow_held = 0;
      mismatches = 0;
      no_idle = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[row]) begin
         send_request(directed_plan[row].cmd, directed_plan[row].item_id,
                      directed_plan[row].prio, directed_plan[row].fixed,
                      directed_plan[row].rsp);
      end

      // Fill and drain phases push the queue to both ends; narrow priority
      // ranges produce many ties to exercise arrival order among equals.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase == 0 || $urandom_range(0, 3) == 0) begin
            drain_responses();
         end
         no_idle = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0: insert_pct = 80;
            1: insert_pct = 20;
            default: insert_pct = 50;
         endcase
         case ($urandom_range(0, 3))
            0: begin
               prio_lo = 0;
               prio_hi = 2;
            end
            1: begin
               prio_lo = 13;
               prio_hi = 15;
            end
            default: begin
               prio_lo = 0;
               prio_hi = 15;
            end
         endcase
         for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            send_request(cmd, ID_W'($urandom), PRIO_W'($urandom_range(prio_lo, prio_hi)),
                         1'b0, '0);
            sent++;
         end
         phase++;
      end

      no_idle = 1'b0;
      drain_responses();
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_sorted_priority_queue_core OK");
      end else begin
         $display("tb_sorted_priority_queue_core NOT OK");
      end
      $finish;
   end

   always @(posedge clock) begin
      queue_rsp_t want;
      if (reset) begin
         rsp_hold = 0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_rsps.size() == 0) begin
               $error("response transfer with no request pending");
               mismatches++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  mismatches++;
               end
               if (rsp_ch.out_id !== want.out_id) begin
                  $error("out_id: expected %0h, got %0h", want.out_id, rsp_ch.out_id);
                  mismatches++;
               end
               if (rsp_ch.out_priority !== want.out_priority) begin
                  $error("out_priority: expected %0d, got %0d", want.out_priority,
                         rsp_ch.out_priority);
                  mismatches++;
               end
               if (rsp_ch.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                  mismatches++;
               end
            end
            rsp_hold = random_pause();
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ch.ready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_sorted_priority_queue_core NOT OK");
         $finish;
      end
   end

endmodule
